[hw/rtl/cro_pkg.sv]
// Shared constants for the circle / rectangle overlap pipeline.
package cro_pkg;

   // Default coordinate width, fixed point with eight fraction bits
   localparam int COORD_BITS_DEF = 24;

   // Shape kind codes
   localparam logic KIND_RECT   = 1'b0;
   localparam logic KIND_CIRCLE = 1'b1;

   // Pair codes: which test applies to the pair
   localparam logic [1:0] MODE_CC  = 2'd0;
   localparam logic [1:0] MODE_RR  = 2'd1;
   localparam logic [1:0] MODE_MIX = 2'd2;

endpackage

[hw/rtl/cro_axis_gap.sv]
// Per-axis distance magnitude: centre to centre, or centre to nearer rectangle edge.
module cro_axis_gap
   import cro_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  logic [1:0]                   mode,
   input  logic signed [COORD_BITS-1:0] pnt,
   input  logic signed [COORD_BITS-1:0] lo,
   input  logic signed [COORD_BITS-1:0] hi,
   output logic [COORD_BITS-1:0]        gap_mag
);

   logic [COORD_BITS:0] lo_m_p;
   logic [COORD_BITS:0] p_m_lo;
   logic [COORD_BITS:0] p_m_hi;
   logic                lo_m_p_pos;
   logic                p_m_hi_pos;

   // Form all differences at once, one bit wider than the coordinates
   assign lo_m_p = {lo[COORD_BITS-1], lo} - {pnt[COORD_BITS-1], pnt};
   assign p_m_lo = {pnt[COORD_BITS-1], pnt} - {lo[COORD_BITS-1], lo};
   assign p_m_hi = {pnt[COORD_BITS-1], pnt} - {hi[COORD_BITS-1], hi};

   assign lo_m_p_pos = !lo_m_p[COORD_BITS] && (lo_m_p != '0);
   assign p_m_hi_pos = !p_m_hi[COORD_BITS] && (p_m_hi != '0);

   // Pick the magnitude; it always fits the coordinate width
   always_comb begin
      case (mode)
         MODE_CC: begin
            gap_mag = lo_m_p[COORD_BITS] ? p_m_lo[COORD_BITS-1:0]
                                         : lo_m_p[COORD_BITS-1:0];
         end
         MODE_MIX: begin
            if (lo_m_p_pos) begin
               gap_mag = lo_m_p[COORD_BITS-1:0];
            end else if (p_m_hi_pos) begin
               gap_mag = p_m_hi[COORD_BITS-1:0];
            end else begin
               gap_mag = '0;
            end
         end
         default: begin
            gap_mag = '0;
         end
      endcase
   end

endmodule

[hw/rtl/circle_rect_overlap_test.sv]
// Top level of the four-stage circle / rectangle overlap pipeline.
//
// Usage: present a pair of shapes on the req_ channel (valid/ready). Each
// shape is a rectangle (kind 0, edges x..x_end, y..y_end) or a circle
// (kind 1, centre x, y and radius). One beat on rsp_ answers each pair:
// rsp_overlaps is 1 when the shapes touch or overlap, edges inclusive.
// rsp_valid rises once the request has passed the gap select, square, sum
// and compare registers. Throughput: one pair per cycle while rsp_ready is
// high; every stage, including the three coordinate-width squarers, takes a
// new pair each cycle unless the stage after it is stalled.
// Each stage has its own valid bit and moves on whenever the stage after it
// is empty or moving, so bubbles close up while rsp_ready is low. req_ready
// falls only once all four stages hold a pair; nothing is dropped or
// repeated under a stall.
// Reset (synchronous, active high) empties every stage; no result is pending
// afterwards and the data registers need no clearing.
module circle_rect_overlap_test
   import cro_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                         req_a_kind,
   input  logic signed [COORD_BITS-1:0] req_a_x,
   input  logic signed [COORD_BITS-1:0] req_a_y,
   input  logic signed [COORD_BITS-1:0] req_a_x_end,
   input  logic signed [COORD_BITS-1:0] req_a_y_end,
   input  logic [COORD_BITS-2:0]        req_a_radius,
   input  logic                         req_b_kind,
   input  logic signed [COORD_BITS-1:0] req_b_x,
   input  logic signed [COORD_BITS-1:0] req_b_y,
   input  logic signed [COORD_BITS-1:0] req_b_x_end,
   input  logic signed [COORD_BITS-1:0] req_b_y_end,
   input  logic [COORD_BITS-2:0]        req_b_radius,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic                         rsp_overlaps
);

   localparam int SQ_BITS  = 2 * COORD_BITS;
   localparam int SUM_BITS = SQ_BITS + 1;

   // Stage valid bits and stall chain
   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic v1_in, v2_in, v3_in, v4_in;
   logic rdy1, rdy2, rdy3, rdy4;

   // Stage 1: pair code, rectangle hit, axis magnitudes, radius
   logic [1:0]                   mode1_ff, mode1_in;
   logic                         rrhit1_ff, rrhit1_in;
   logic [COORD_BITS-1:0]        mx1_ff, mx1_in;
   logic [COORD_BITS-1:0]        my1_ff, my1_in;
   logic [COORD_BITS-1:0]        rad1_ff, rad1_in;

   // Stage 2: squares
   logic [1:0]                   mode2_ff;
   logic                         rrhit2_ff;
   logic [SQ_BITS-1:0]           sqx2_ff, sqx2_in;
   logic [SQ_BITS-1:0]           sqy2_ff, sqy2_in;
   logic [SQ_BITS-1:0]           sqr2_ff, sqr2_in;

   // Stage 3: distance sum
   logic [1:0]                   mode3_ff;
   logic                         rrhit3_ff;
   logic [SUM_BITS-1:0]          sum3_ff, sum3_in;
   logic [SQ_BITS-1:0]           sqr3_ff;

   // Stage 4: answer
   logic                         hit4_ff, hit4_in;

   // Operand routing for the axis units
   logic signed [COORD_BITS-1:0] px, lox, hix;
   logic signed [COORD_BITS-1:0] py, loy, hiy;
   logic                         a_is_circle;

   // Let a stage take new data when it is empty or its content moves on
   assign rdy4      = !v4_ff || rsp_ready;
   assign rdy3      = !v3_ff || rdy4;
   assign rdy2      = !v2_ff || rdy3;
   assign rdy1      = !v1_ff || rdy2;
   assign req_ready = rdy1;

   assign v1_in = rdy1 ? req_valid : v1_ff;
   assign v2_in = rdy2 ? v1_ff : v2_ff;
   assign v3_in = rdy3 ? v2_ff : v3_ff;
   assign v4_in = rdy4 ? v3_ff : v4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
         v4_ff <= v4_in;
      end
   end

   // Classify the pair and put the circle first for a mixed pair
   assign a_is_circle = (req_a_kind == KIND_CIRCLE);

   always_comb begin
      if (req_a_kind == KIND_CIRCLE && req_b_kind == KIND_CIRCLE) begin
         mode1_in = MODE_CC;
      end else if (req_a_kind == KIND_RECT && req_b_kind == KIND_RECT) begin
         mode1_in = MODE_RR;
      end else begin
         mode1_in = MODE_MIX;
      end
   end

   assign px  = a_is_circle ? req_a_x     : req_b_x;
   assign lox = a_is_circle ? req_b_x     : req_a_x;
   assign hix = a_is_circle ? req_b_x_end : req_a_x_end;
   assign py  = a_is_circle ? req_a_y     : req_b_y;
   assign loy = a_is_circle ? req_b_y     : req_a_y;
   assign hiy = a_is_circle ? req_b_y_end : req_a_y_end;

   cro_axis_gap #(
      .COORD_BITS (COORD_BITS)
   ) u_gap_x (
      .mode    (mode1_in),
      .pnt     (px),
      .lo      (lox),
      .hi      (hix),
      .gap_mag (mx1_in)
   );

   cro_axis_gap #(
      .COORD_BITS (COORD_BITS)
   ) u_gap_y (
      .mode    (mode1_in),
      .pnt     (py),
      .lo      (loy),
      .hi      (hiy),
      .gap_mag (my1_in)
   );

   // Inclusive interval test on both axes for two rectangles
   assign rrhit1_in = (req_a_x <= req_b_x_end) && (req_a_x_end >= req_b_x) &&
                      (req_a_y <= req_b_y_end) && (req_a_y_end >= req_b_y);

   // Sum of radii for two circles, otherwise the circle's own radius
   always_comb begin
      case (mode1_in)
         MODE_CC: begin
            rad1_in = {1'b0, req_a_radius} + {1'b0, req_b_radius};
         end
         default: begin
            rad1_in = {1'b0, (a_is_circle ? req_a_radius : req_b_radius)};
         end
      endcase
   end

   // Exact squares
   assign sqx2_in = SQ_BITS'(mx1_ff)  * SQ_BITS'(mx1_ff);
   assign sqy2_in = SQ_BITS'(my1_ff)  * SQ_BITS'(my1_ff);
   assign sqr2_in = SQ_BITS'(rad1_ff) * SQ_BITS'(rad1_ff);

   // Squared distance
   assign sum3_in = {1'b0, sqx2_ff} + {1'b0, sqy2_ff};

   // Final decision, inclusive
   assign hit4_in = (mode3_ff == MODE_RR) ? rrhit3_ff
                                          : (sum3_ff <= {1'b0, sqr3_ff});

   // Advance the data registers with their valid bits
   always_ff @(posedge clock) begin
      if (rdy1) begin
         mode1_ff  <= mode1_in;
         rrhit1_ff <= rrhit1_in;
         mx1_ff    <= mx1_in;
         my1_ff    <= my1_in;
         rad1_ff   <= rad1_in;
      end
      if (rdy2) begin
         mode2_ff  <= mode1_ff;
         rrhit2_ff <= rrhit1_ff;
         sqx2_ff   <= sqx2_in;
         sqy2_ff   <= sqy2_in;
         sqr2_ff   <= sqr2_in;
      end
      if (rdy3) begin
         mode3_ff  <= mode2_ff;
         rrhit3_ff <= rrhit2_ff;
         sum3_ff   <= sum3_in;
         sqr3_ff   <= sqr2_ff;
      end
      if (rdy4) begin
         hit4_ff   <= hit4_in;
      end
   end

   assign rsp_valid    = v4_ff;
   assign rsp_overlaps = hit4_ff;

`ifndef SYNTH
   // Back-pressure at the input only when every stage is occupied
   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (v1_ff && v2_ff && v3_ff && v4_ff))
      else $error("req_ready low with an empty stage");

   // A pair in stage 1 that may move must arrive in stage 2
   assert property (@(posedge clock) disable iff (reset)
      (v1_ff && rdy2) |=> v2_ff)
      else $error("pair lost between stage 1 and stage 2");

   // Two rectangles take the interval result unchanged
   assert property (@(posedge clock) disable iff (reset)
      (v3_ff && rdy4 && mode3_ff == MODE_RR) |=> (rsp_overlaps == $past(rrhit3_ff)))
      else $error("rectangle pair answer differs from interval test");
`endif

endmodule
